// ----- sv/wrms_pkg.sv -----
// shared types and constants for the windowed rms and offset block
`default_nettype none

package wrms_pkg;

    localparam int LEN_W          = 13;
    localparam int SAMPLE_W       = 16;
    localparam int RESULT_W       = 16;
    localparam int MIN_WINDOW     = 16;
    localparam logic [LEN_W-1:0] RESET_LENGTH = 13'd800;

    // integer square root of the mean square, which never exceeds 2^30
    localparam int ROOT_RAD_W     = 32;
    localparam int ROOT_W         = 16;
    localparam int ROOT_STEPS     = ROOT_RAD_W / 2;
    localparam int ROOT_REM_W     = ROOT_W + 4;

    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W        = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

// ----- sv/windowed_rms_and_offset.sv -----
// windowed rms and dc offset: top level
//
// sample channel: sample_valid/sample_ready carry one signed 16-bit sample per
// transaction; a sample is taken every cycle while sample_ready is high.
// result channel: result_valid/result_ready carry rms_value and dc_offset, one
// transaction per closed window.
// cfg_write_en with window_length writes the window size (clamped to 16 up to
// MAX_WINDOW); it resets to 800.
// a closed window goes into a two-entry queue; the back end pops it when
// idle, runs two bit-serial restoring divisions side by side over one
// divisor, then the two-bit-per-cycle root, and loads the result register
// from its finish state.
// while the result register waits for result_ready the back end holds its
// finished result and the accumulator keeps taking samples; sample_ready drops
// only when a window closes while the queue is full.
// reset clears the sums, the count, the queue and the result register.
`default_nettype none

module windowed_rms_and_offset #(
    parameter int MAX_WINDOW = 4096
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write_en,
    input  wire logic [wrms_pkg::LEN_W-1:0]           window_length,
    input  wire logic                                 sample_valid,
    output logic                                      sample_ready,
    input  wire logic signed [wrms_pkg::SAMPLE_W-1:0] sample,
    output logic                                      result_valid,
    input  wire logic                                 result_ready,
    output logic [wrms_pkg::RESULT_W-1:0]             rms_value,
    output logic signed [wrms_pkg::RESULT_W-1:0]      dc_offset
);
    import wrms_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW) + 1;
    localparam int SQ_W  = 31 + $clog2(MAX_WINDOW);
    localparam int SUM_W = 17 + $clog2(MAX_WINDOW);
    localparam int JOB_W = SQ_W + SUM_W + CNT_W;

    logic                    push;
    logic                    pop;
    q_status_t               q_status;
    logic [SQ_W-1:0]         in_sq;
    logic signed [SUM_W-1:0] in_sum;
    logic [CNT_W-1:0]        in_n;
    logic [JOB_W-1:0]        head;
    logic [SQ_W-1:0]         out_sq;
    logic signed [SUM_W-1:0] out_sum;
    logic [CNT_W-1:0]        out_n;

    wrms_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .window_length (window_length),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .sample        (sample),
        .q_status      (q_status),
        .push          (push),
        .job_sq        (in_sq),
        .job_sum       (in_sum),
        .job_n         (in_n)
    );

    wrms_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({in_sq, in_sum, in_n}),
        .pop       (pop),
        .pop_data  (head),
        .status    (q_status)
    );

    assign out_sq  = head[JOB_W-1 -: SQ_W];
    assign out_sum = $signed(head[CNT_W +: SUM_W]);
    assign out_n   = head[CNT_W-1:0];

    wrms_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .pop          (pop),
        .job_sq       (out_sq),
        .job_sum      (out_sum),
        .job_n        (out_n),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .rms_value    (rms_value),
        .dc_offset    (dc_offset)
    );

endmodule

`default_nettype wire

// ----- sv/wrms_front.sv -----
// sample accumulator: sums of squares and values, window close detection
`default_nettype none

module wrms_front #(
    parameter int MAX_WINDOW = 4096
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     cfg_write_en,
    input  wire logic [wrms_pkg::LEN_W-1:0]               window_length,
    input  wire logic                                     sample_valid,
    output logic                                          sample_ready,
    input  wire logic signed [wrms_pkg::SAMPLE_W-1:0]     sample,
    input  wire wrms_pkg::q_status_t                      q_status,
    output logic                                          push,
    output logic [31+$clog2(MAX_WINDOW)-1:0]              job_sq,
    output logic signed [17+$clog2(MAX_WINDOW)-1:0]       job_sum,
    output logic [$clog2(MAX_WINDOW)+1-1:0]               job_n
);
    import wrms_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW) + 1;
    localparam int SQ_W  = 31 + $clog2(MAX_WINDOW);
    localparam int SUM_W = 17 + $clog2(MAX_WINDOW);
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_WINDOW);
    localparam logic [CMP_W-1:0] MIN_C = CMP_W'(MIN_WINDOW);

    logic [LEN_W-1:0]        window_length_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0]        count_reg;

    logic [CMP_W-1:0]        len_ext;
    logic [CMP_W-1:0]        eff_len;
    logic [CNT_W-1:0]        cnt_inc;
    logic                    closing;
    logic                    accept;
    logic signed [31:0]      prod;
    logic [SQ_W-1:0]         sq_total;
    logic signed [SUM_W-1:0] sum_total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= RESET_LENGTH;
        end
        else if (cfg_write_en)
        begin
            window_length_reg <= window_length;
        end
    end

    // clamp the programmed length into the supported range
    always_comb
    begin
        len_ext = CMP_W'(window_length_reg);
        if (len_ext < MIN_C)
            eff_len = MIN_C;
        else if (len_ext > MAX_C)
            eff_len = MAX_C;
        else
            eff_len = len_ext;
    end

    assign cnt_inc      = CNT_W'(count_reg + 1'b1);
    assign closing      = CMP_W'(cnt_inc) >= eff_len;
    assign sample_ready = !(closing && q_status.full);
    assign accept       = sample_valid && sample_ready;

    assign prod      = sample * sample;
    assign sq_total  = sq_reg + SQ_W'(prod[30:0]);
    assign sum_total = sum_reg + SUM_W'(sample);

    assign push    = accept && closing;
    assign job_sq  = sq_total;
    assign job_sum = sum_total;
    assign job_n   = cnt_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg    <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            if (closing)
            begin
                sq_reg    <= '0;
                sum_reg   <= '0;
                count_reg <= '0;
            end
            else
            begin
                sq_reg    <= sq_total;
                sum_reg   <= sum_total;
                count_reg <= cnt_inc;
            end
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("window pushed into a full queue");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) < MAX_C)
        else $error("sample count reached the maximum window");

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (count_reg == '0))
        else $error("count not cleared after window close");

endmodule

`default_nettype wire

// ----- sv/wrms_queue.sv -----
// short queue of closed windows between the accumulator and the divider
`default_nettype none

module wrms_queue #(
    parameter int WIDTH = 85
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output wrms_pkg::q_status_t   status
);
    import wrms_pkg::*;

    logic [WIDTH-1:0]   mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QFILL_W-1:0] fill_reg;

    assign status.full  = fill_reg == QFILL_W'(QUEUE_DEPTH);
    assign status.empty = fill_reg == '0;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= QPTR_W'(wr_ptr_reg + 1'b1);
            if (pop)
                rd_ptr_reg <= QPTR_W'(rd_ptr_reg + 1'b1);
            if (push && !pop)
                fill_reg <= QFILL_W'(fill_reg + 1'b1);
            else if (pop && !push)
                fill_reg <= QFILL_W'(fill_reg - 1'b1);
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue popped while empty");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> !status.full)
        else $error("queue written while full");

endmodule

`default_nettype wire

// ----- sv/wrms_back.sv -----
// divider and square root sequencer with the result register
`default_nettype none

module wrms_back #(
    parameter int MAX_WINDOW = 4096
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire wrms_pkg::q_status_t                      q_status,
    output logic                                          pop,
    input  wire logic [31+$clog2(MAX_WINDOW)-1:0]         job_sq,
    input  wire logic signed [17+$clog2(MAX_WINDOW)-1:0]  job_sum,
    input  wire logic [$clog2(MAX_WINDOW)+1-1:0]          job_n,
    output logic                                          result_valid,
    input  wire logic                                     result_ready,
    output logic [wrms_pkg::RESULT_W-1:0]                 rms_value,
    output logic signed [wrms_pkg::RESULT_W-1:0]          dc_offset
);
    import wrms_pkg::*;

    localparam int CNT_W  = $clog2(MAX_WINDOW) + 1;
    localparam int SQ_W   = 31 + $clog2(MAX_WINDOW);
    localparam int SUM_W  = 17 + $clog2(MAX_WINDOW);
    localparam int STEP_W = $clog2(SQ_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_ROOT,
        S_DONE
    } state_t;

    state_t                  state_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [CNT_W-1:0]        n_reg;
    logic [SQ_W-1:0]         sq_dvd_reg;
    logic [CNT_W-1:0]        sq_rem_reg;
    logic [SQ_W-1:0]         mg_dvd_reg;
    logic [CNT_W-1:0]        mg_rem_reg;
    logic                    neg_reg;
    logic [RESULT_W-1:0]     mean_reg;
    logic [ROOT_RAD_W-1:0]   rad_reg;
    logic [ROOT_REM_W-1:0]   srem_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic                    result_valid_reg;
    logic [RESULT_W-1:0]     rms_reg;
    logic [RESULT_W-1:0]     dc_reg;

    logic [SUM_W-1:0]        job_mag;
    logic [CNT_W:0]          sq_trial;
    logic                    sq_ge;
    logic [CNT_W-1:0]        sq_rem_next;
    logic [SQ_W-1:0]         sq_dvd_next;
    logic [CNT_W:0]          mg_trial;
    logic                    mg_ge;
    logic [CNT_W-1:0]        mg_rem_next;
    logic [SQ_W-1:0]         mg_dvd_next;
    logic [ROOT_REM_W-1:0]   s_cand;
    logic [ROOT_REM_W-1:0]   s_trial;
    logic                    s_ge;
    logic [ROOT_REM_W-1:0]   srem_next;
    logic [ROOT_W-1:0]       root_next;
    logic [RESULT_W-1:0]     mean_mag;
    logic                    out_free;

    assign job_mag = job_sum[SUM_W-1] ? SUM_W'(-job_sum) : SUM_W'(job_sum);
    assign pop     = (state_reg == S_IDLE) && !q_status.empty;

    // restoring division, one quotient bit of each dividend per cycle
    always_comb
    begin
        sq_trial    = {sq_rem_reg, sq_dvd_reg[SQ_W-1]};
        sq_ge       = sq_trial >= {1'b0, n_reg};
        sq_rem_next = sq_ge ? CNT_W'(sq_trial - {1'b0, n_reg}) : sq_trial[CNT_W-1:0];
        sq_dvd_next = {sq_dvd_reg[SQ_W-2:0], sq_ge};

        mg_trial    = {mg_rem_reg, mg_dvd_reg[SQ_W-1]};
        mg_ge       = mg_trial >= {1'b0, n_reg};
        mg_rem_next = mg_ge ? CNT_W'(mg_trial - {1'b0, n_reg}) : mg_trial[CNT_W-1:0];
        mg_dvd_next = {mg_dvd_reg[SQ_W-2:0], mg_ge};
    end

    // digit by digit square root, two radicand bits per cycle
    always_comb
    begin
        s_cand    = {srem_reg[ROOT_REM_W-3:0], rad_reg[ROOT_RAD_W-1 -: 2]};
        s_trial   = {2'b00, root_reg, 2'b01};
        s_ge      = s_cand >= s_trial;
        srem_next = s_ge ? ROOT_REM_W'(s_cand - s_trial) : s_cand;
        root_next = {root_reg[ROOT_W-2:0], s_ge};
    end

    assign mean_mag = mg_dvd_next[RESULT_W-1:0];
    assign out_free = !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            step_reg         <= '0;
            n_reg            <= '0;
            sq_dvd_reg       <= '0;
            sq_rem_reg       <= '0;
            mg_dvd_reg       <= '0;
            mg_rem_reg       <= '0;
            neg_reg          <= 1'b0;
            mean_reg         <= '0;
            rad_reg          <= '0;
            srem_reg         <= '0;
            root_reg         <= '0;
            result_valid_reg <= 1'b0;
            rms_reg          <= '0;
            dc_reg           <= '0;
        end
        else
        begin
            // the finish state loads the result register itself
            if (result_valid_reg && result_ready && (state_reg != S_DONE))
                result_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        n_reg      <= job_n;
                        sq_dvd_reg <= job_sq;
                        sq_rem_reg <= '0;
                        mg_dvd_reg <= SQ_W'(job_mag);
                        mg_rem_reg <= '0;
                        neg_reg    <= job_sum[SUM_W-1];
                        step_reg   <= STEP_W'(SQ_W - 1);
                        state_reg  <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    sq_dvd_reg <= sq_dvd_next;
                    sq_rem_reg <= sq_rem_next;
                    mg_dvd_reg <= mg_dvd_next;
                    mg_rem_reg <= mg_rem_next;
                    if (step_reg == '0)
                    begin
                        rad_reg   <= sq_dvd_next[ROOT_RAD_W-1:0];
                        mean_reg  <= neg_reg ? RESULT_W'(-mean_mag) : mean_mag;
                        srem_reg  <= '0;
                        root_reg  <= '0;
                        step_reg  <= STEP_W'(ROOT_STEPS - 1);
                        state_reg <= S_ROOT;
                    end
                    else
                    begin
                        step_reg <= STEP_W'(step_reg - 1'b1);
                    end
                end
                S_ROOT:
                begin
                    rad_reg  <= {rad_reg[ROOT_RAD_W-3:0], 2'b00};
                    srem_reg <= srem_next;
                    root_reg <= root_next;
                    if (step_reg == '0)
                        state_reg <= S_DONE;
                    else
                        step_reg <= STEP_W'(step_reg - 1'b1);
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        rms_reg          <= root_reg;
                        dc_reg           <= mean_reg;
                        result_valid_reg <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign rms_value    = rms_reg;
    assign dc_offset    = dc_reg;

    a_pop_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == S_DIV))
        else $error("job popped but division did not start");

    a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && result_valid_reg && !result_ready)
            |=> (state_reg == S_DONE))
        else $error("result overwritten while the receiver stalls");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside the finish state");

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// self-checking testbench for the windowed rms and dc offset block
`timescale 1ns / 1ps

typedef struct {
    logic        [wrms_pkg::RESULT_W-1:0] rms;
    logic signed [wrms_pkg::RESULT_W-1:0] dc;
} window_stats_t;

// tracks the window sums and queues the stats each closed window must produce
class window_tracker;
    int unsigned                length_cap;
    logic [wrms_pkg::LEN_W-1:0] length_reg;
    bit [63:0]                  square_acc;
    longint                     sum_acc;
    int unsigned                taken;
    window_stats_t              pending_windows[$];
    int                         mismatches;
    int                         windows_checked;

    function new(int unsigned cap);
        length_cap      = cap;
        length_reg      = wrms_pkg::RESET_LENGTH;
        square_acc      = 0;
        sum_acc         = 0;
        taken           = 0;
        mismatches      = 0;
        windows_checked = 0;
    endfunction

    function void set_length(logic [wrms_pkg::LEN_W-1:0] value);
        length_reg = value;
    endfunction

    function int unsigned span();
        int unsigned n;
        n = length_reg;
        if (n < wrms_pkg::MIN_WINDOW)
            n = wrms_pkg::MIN_WINDOW;
        if (n > length_cap)
            n = length_cap;
        return n;
    endfunction

    // floor of the square root, built one result bit at a time from the top
    function bit [63:0] floor_root(bit [63:0] x);
        bit [63:0] root;
        bit [63:0] trial;
        root = 0;
        for (int b = 16; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    function void take_sample(logic signed [wrms_pkg::SAMPLE_W-1:0] s);
        longint        v;
        window_stats_t w;
        v          = s;
        square_acc += v * v;
        sum_acc    += v;
        taken++;
        if (taken >= span())
        begin
            // divide by the samples actually taken, which exceed the length
            // when the length was lowered mid-window
            w.rms = wrms_pkg::RESULT_W'(floor_root(square_acc / taken));
            w.dc  = wrms_pkg::RESULT_W'(sum_acc / longint'(taken));
            pending_windows.push_back(w);
            square_acc = 0;
            sum_acc    = 0;
            taken      = 0;
        end
    endfunction

    function void flag(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    function void check_window(logic [wrms_pkg::RESULT_W-1:0] rms,
                               logic signed [wrms_pkg::RESULT_W-1:0] dc);
        window_stats_t w;
        if (pending_windows.size() == 0)
        begin
            flag($sformatf("unexpected result rms %0d dc %0d", rms, dc));
            return;
        end
        w = pending_windows.pop_front();
        windows_checked++;
        if (rms !== w.rms)
            flag($sformatf("rms_value expected %0d got %0d", w.rms, rms));
        if (dc !== w.dc)
            flag($sformatf("dc_offset expected %0d got %0d", w.dc, dc));
    endfunction
endclass

module testbench;

    localparam int MAX_WINDOW  = 4096;
    localparam int SETTLE      = 80;
    localparam int LONG_HOLD   = 600;
    localparam int IDLE_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 470;

    typedef enum int {MIX_FULL, MIX_OFFSET, MIX_EXTREME, MIX_NEAR_ZERO} sample_mix_t;
    typedef enum int {RX_OPEN, RX_LIGHT, RX_HALF, RX_PULSED} rx_mode_t;

    localparam logic signed [15:0] CORNER_SAMPLES [7] =
        '{16'sd32767, -16'sd32768, 16'sd0, 16'sd1, -16'sd1, 16'sd21845, -16'sd21846};

    logic                                 clk;
    logic                                 rst_n;
    logic                                 cfg_write_en;
    logic [wrms_pkg::LEN_W-1:0]           window_length;
    logic                                 sample_valid;
    logic                                 sample_ready;
    logic signed [wrms_pkg::SAMPLE_W-1:0] sample;
    logic                                 result_valid;
    logic                                 result_ready;
    logic [wrms_pkg::RESULT_W-1:0]        rms_value;
    logic signed [wrms_pkg::RESULT_W-1:0] dc_offset;

    window_tracker tracker;
    int            burst_left;
    int            samples_taken;
    int            settings_written;
    int            hold_asks;
    int            hold_done;
    int            idle_cycles;

    windowed_rms_and_offset #(
        .MAX_WINDOW(MAX_WINDOW)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .window_length(window_length),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .rms_value    (rms_value),
        .dc_offset    (dc_offset)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic signed [15:0] rand_sample(sample_mix_t mix, int centre);
        int v;
        case (mix)
            MIX_FULL:   v = int'($signed(16'($urandom)));
            MIX_OFFSET: v = centre + int'($urandom_range(0, 4000)) - 2000;
            MIX_EXTREME:
                case ($urandom_range(0, 3))
                    0:       v = -32768;
                    1:       v = 32767;
                    2:       v = -32767;
                    default: v = $urandom_range(0, 1) ? -1 : 1;
                endcase
            default:    v = int'($urandom_range(0, 16)) - 8;
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    // one sample transaction; bursts of random length with random gaps unless steady
    task automatic feed(input logic signed [15:0] s, input bit steady);
        int gap;
        if (!steady && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk) sample_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        if (!steady)
            burst_left--;
        @(negedge clk);
        sample_valid <= 1'b1;
        sample       <= s;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        tracker.take_sample(s);
        samples_taken++;
    endtask

    // drain all expected windows, then give the accumulator time to go quiet
    task automatic settle();
        @(negedge clk) sample_valid <= 1'b0;
        while (tracker.pending_windows.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_length(input logic [wrms_pkg::LEN_W-1:0] value);
        @(negedge clk);
        cfg_write_en  <= 1'b1;
        window_length <= value;
        @(negedge clk) cfg_write_en <= 1'b0;
        tracker.set_length(value);
        settings_written++;
    endtask

    // receiver: its own ready pattern, plus a long hold on request
    initial
    begin
        rx_mode_t mode;
        int       tick;
        mode         = RX_OPEN;
        tick         = 0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asks != hold_done)
            begin
                result_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_done++;
            end
            else
            begin
                if (tick % 64 == 0)
                    mode = rx_mode_t'($urandom_range(0, 3));
                case (mode)
                    RX_OPEN:  result_ready <= 1'b1;
                    RX_LIGHT: result_ready <= ($urandom_range(0, 3) != 0);
                    RX_HALF:  result_ready <= $urandom_range(0, 1);
                    default:  result_ready <= (tick % 8 < 3);
                endcase
                tick++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            tracker.check_window(rms_value, dc_offset);
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((sample_valid && sample_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        int          len;
        int          eff;
        int          total;
        int          centre;
        int          random_items;
        sample_mix_t mix;

        tracker          = new(MAX_WINDOW);
        burst_left       = 0;
        samples_taken    = 0;
        settings_written = 0;
        hold_asks        = 0;
        hold_done        = 0;
        idle_cycles      = 0;
        random_items     = 0;
        rst_n            = 1'b0;
        cfg_write_en     = 1'b0;
        window_length    = '0;
        sample_valid     = 1'b0;
        sample           = '0;
        repeat (2) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // one window at the reset length
        for (int i = 0; i < 800; i++)
            feed(rand_sample(MIX_FULL, 0), 1'b0);
        settle();

        // zero length acts as the minimum; full-scale negative gives the top rms
        write_length(13'd0);
        for (int i = 0; i < 16; i++)
            feed(-16'sd32768, 1'b0);
        settle();

        // just below the minimum; corners plus a negative mean that must truncate up
        write_length(13'd15);
        foreach (CORNER_SAMPLES[i])
            feed(CORNER_SAMPLES[i], 1'b0);
        for (int i = 0; i < 9; i++)
            feed(-16'sd7, 1'b0);
        settle();

        // long window left partly filled, then the length drops below the count
        write_length(13'(MAX_WINDOW));
        for (int i = 0; i < 30; i++)
            feed(rand_sample(MIX_FULL, 0), 1'b0);
        settle();
        write_length(13'(MAX_WINDOW + 1));
        for (int i = 0; i < 10; i++)
            feed(rand_sample(MIX_OFFSET, -20000), 1'b0);
        settle();
        write_length(13'd16);
        feed(16'sd32767, 1'b0);
        settle();

        // all-ones length clamps to the largest window; a short length then closes it
        write_length('1);
        for (int i = 0; i < 300; i++)
            feed(rand_sample(i < 150 ? MIX_EXTREME : MIX_OFFSET, -30000), 1'b0);
        settle();
        write_length(13'd16);
        feed(-16'sd32768, 1'b0);
        settle();

        // receiver holds off while short windows keep closing
        write_length(13'd16);
        hold_asks++;
        for (int i = 0; i < 160; i++)
            feed(rand_sample(MIX_FULL, 0), 1'b1);
        settle();

        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(0, 15);
                1:       len = 16;
                2:       len = $urandom_range(65, 400);
                default: len = $urandom_range(17, 64);
            endcase
            write_length(13'(len));
            eff    = tracker.span();
            total  = eff * $urandom_range(1, 3);
            // sometimes leave a partial window for the next setting to inherit
            if ($urandom_range(0, 2) == 0)
                total += $urandom_range(1, eff - 1);
            if (total > RANDOM_ITEMS - random_items)
                total = RANDOM_ITEMS - random_items;
            mix    = sample_mix_t'($urandom_range(0, 3));
            centre = int'($urandom_range(0, 65535)) - 32768;
            for (int i = 0; i < total; i++)
                feed(rand_sample(mix, centre), 1'b0);
            random_items += total;
            settle();
        end

        $display("covered %0d samples and %0d closed windows over %0d length settings,",
                 samples_taken, tracker.windows_checked, settings_written);
        $display("with clamped and mid-window lengths and a %0d-cycle result stall",
                 LONG_HOLD);
        if (tracker.mismatches == 0 && tracker.pending_windows.size() == 0)
            $display("SUCCESS");
        else
        begin
            $display("%0d mismatches, %0d windows never reported",
                     tracker.mismatches, tracker.pending_windows.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule
